[rtl/core/plc_pkg.sv]
// Shared types, format codes, float constants and small helpers for the luminance converter.
`default_nettype none

package plc_pkg;

  // Pixel format codes held in the format register
  localparam logic [2:0] FMT_F32     = 3'd0;
  localparam logic [2:0] FMT_F16     = 3'd1;
  localparam logic [2:0] FMT_U16_RGB = 3'd2;
  localparam logic [2:0] FMT_U8_BGR  = 3'd3;
  localparam logic [2:0] FMT_U8_RG   = 3'd4;
  localparam logic [2:0] FMT_R16     = 3'd5;
  localparam logic [2:0] FMT_R8      = 3'd6;
  localparam logic [2:0] FMT_NONE    = 3'd7;

  // Single-precision constants
  localparam logic [31:0] F_ONE     = 32'h3F80_0000;
  localparam logic [31:0] F_W_RED   = 32'h3E59_B3D0;
  localparam logic [31:0] F_W_GRN   = 32'h3F37_1759;
  localparam logic [31:0] F_W_BLU   = 32'h3D93_DD98;
  localparam logic [31:0] F_INV255  = 32'h3B80_8081;
  localparam logic [31:0] F_INV65K  = 32'h3780_0080;
  localparam logic [31:0] F_QNAN    = 32'h7FC0_0000;

  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned FP_STAGES = 4;

  typedef struct packed {
    logic [31:0] chan0;
    logic [31:0] chan1;
    logic [31:0] chan2;
  } pix_t;

  typedef struct packed {
    logic [31:0] luma_bits;
    logic        zeroed;
  } luma_t;

  // Special-value summary of an operation
  typedef struct packed {
    logic nan;
    logic inf;
    logic zero;
  } spc_t;

  // Leading zero counts
  function automatic logic [3:0] lzc10(input logic [9:0] v);
    logic [3:0] n;
    n = 4'd10;
    for (int i = 0; i < 10; i++) begin
      if (v[i]) n = 4'(9 - i);
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc16(input logic [15:0] v);
    logic [4:0] n;
    n = 5'd16;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) n = 5'(15 - i);
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    n = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    n = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) n = 5'(26 - i);
    end
    return n;
  endfunction

  // Exact unsigned 16-bit integer to single
  function automatic logic [31:0] u16_to_f32(input logic [15:0] v);
    logic [4:0]  lz;
    logic [15:0] m;
    logic [7:0]  ex;
    lz = lzc16(v);
    m  = v << lz;
    ex = 8'd142 - {3'd0, lz};
    if (v == 16'd0) return 32'd0;
    return {1'b0, ex, m[14:0], 8'd0};
  endfunction

  // Exact half to single, subnormals and specials included
  function automatic logic [31:0] half_to_f32(input logic [15:0] h);
    logic       s;
    logic [4:0] ex;
    logic [9:0] man;
    logic [3:0] lz;
    logic [9:0] mn;
    s   = h[15];
    ex  = h[14:10];
    man = h[9:0];
    lz  = lzc10(man);
    mn  = man << (lz + 4'd1);
    if (ex == 5'd0) begin
      if (man == 10'd0) return {s, 31'd0};
      return {s, 8'd112 - {4'd0, lz}, mn, 13'd0};
    end
    if (ex == 5'd31) return {s, 8'hFF, man, 13'd0};
    return {s, {3'd0, ex} + 8'd112, man, 13'd0};
  endfunction

endpackage

`default_nettype wire

[rtl/core/plc_decode.sv]
// Input stage: decodes the channel words into per-lane singles and the unorm scale.
`default_nettype none

module plc_decode (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [2:0]          fmt_i,
  input  plc_pkg::pix_t       pix_i,
  output logic [2:0][31:0]    x_o,
  output logic [31:0]         scale_o
);

  logic [2:0][31:0] x_d, x_q;
  logic [31:0]      scale_d, scale_q;

  // Map stored channels to red, green and blue lanes
  always_comb begin
    x_d     = '0;
    scale_d = plc_pkg::F_ONE;
    unique case (fmt_i)
      plc_pkg::FMT_F32: begin
        x_d[0] = pix_i.chan0;
        x_d[1] = pix_i.chan1;
        x_d[2] = pix_i.chan2;
      end
      plc_pkg::FMT_F16: begin
        x_d[0] = plc_pkg::half_to_f32(pix_i.chan0[15:0]);
        x_d[1] = plc_pkg::half_to_f32(pix_i.chan1[15:0]);
        x_d[2] = plc_pkg::half_to_f32(pix_i.chan2[15:0]);
      end
      plc_pkg::FMT_U16_RGB: begin
        x_d[0]  = plc_pkg::u16_to_f32(pix_i.chan0[15:0]);
        x_d[1]  = plc_pkg::u16_to_f32(pix_i.chan1[15:0]);
        x_d[2]  = plc_pkg::u16_to_f32(pix_i.chan2[15:0]);
        scale_d = plc_pkg::F_INV65K;
      end
      plc_pkg::FMT_U8_BGR: begin
        x_d[0]  = plc_pkg::u16_to_f32({8'd0, pix_i.chan2[7:0]});
        x_d[1]  = plc_pkg::u16_to_f32({8'd0, pix_i.chan1[7:0]});
        x_d[2]  = plc_pkg::u16_to_f32({8'd0, pix_i.chan0[7:0]});
        scale_d = plc_pkg::F_INV255;
      end
      plc_pkg::FMT_U8_RG: begin
        x_d[0]  = plc_pkg::u16_to_f32({8'd0, pix_i.chan0[7:0]});
        x_d[1]  = plc_pkg::u16_to_f32({8'd0, pix_i.chan1[7:0]});
        scale_d = plc_pkg::F_INV255;
      end
      plc_pkg::FMT_R16: begin
        x_d[0]  = plc_pkg::u16_to_f32(pix_i.chan0[15:0]);
        scale_d = plc_pkg::F_INV65K;
      end
      plc_pkg::FMT_R8: begin
        x_d[0]  = plc_pkg::u16_to_f32({8'd0, pix_i.chan0[7:0]});
        scale_d = plc_pkg::F_INV255;
      end
      default: begin
        x_d     = '0;
        scale_d = plc_pkg::F_ONE;
      end
    endcase
  end

  // Hold decoded word
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q     <= x_d;
      scale_q <= scale_d;
    end
  end

  assign x_o     = x_q;
  assign scale_o = scale_q;

endmodule

`default_nettype wire

[rtl/core/plc_fmul.sv]
// Four-stage single-precision multiplier, round to nearest even, subnormals kept.
`default_nettype none

module plc_fmul (
  input  logic                            clk_i,
  input  logic [plc_pkg::FP_STAGES-1:0]   en_i,
  input  logic [31:0]                     a_i,
  input  logic [31:0]                     b_i,
  output logic [31:0]                     p_o
);

  // Stage 1: unpack and normalize subnormal operands
  logic               s1_sign_d, s1_sign_q;
  logic signed [10:0] s1_ea_d, s1_eb_d, s1_ea_q, s1_eb_q;
  logic [23:0]        s1_ma_d, s1_mb_d, s1_ma_q, s1_mb_q;
  plc_pkg::spc_t      s1_spc_d, s1_spc_q;

  logic        a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
  logic [23:0] ma_raw, mb_raw;
  logic [4:0]  a_lz, b_lz;

  always_comb begin
    a_zero = (a_i[30:23] == 8'd0) && (a_i[22:0] == 23'd0);
    b_zero = (b_i[30:23] == 8'd0) && (b_i[22:0] == 23'd0);
    a_inf  = (a_i[30:23] == 8'hFF) && (a_i[22:0] == 23'd0);
    b_inf  = (b_i[30:23] == 8'hFF) && (b_i[22:0] == 23'd0);
    a_nan  = (a_i[30:23] == 8'hFF) && (a_i[22:0] != 23'd0);
    b_nan  = (b_i[30:23] == 8'hFF) && (b_i[22:0] != 23'd0);
    ma_raw = {a_i[30:23] != 8'd0, a_i[22:0]};
    mb_raw = {b_i[30:23] != 8'd0, b_i[22:0]};
    a_lz   = plc_pkg::lzc24(ma_raw);
    b_lz   = plc_pkg::lzc24(mb_raw);
    if (a_i[30:23] == 8'd0) begin
      s1_ma_d = ma_raw << a_lz;
      s1_ea_d = 11'sd1 - $signed({6'd0, a_lz});
    end else begin
      s1_ma_d = ma_raw;
      s1_ea_d = $signed({3'd0, a_i[30:23]});
    end
    if (b_i[30:23] == 8'd0) begin
      s1_mb_d = mb_raw << b_lz;
      s1_eb_d = 11'sd1 - $signed({6'd0, b_lz});
    end else begin
      s1_mb_d = mb_raw;
      s1_eb_d = $signed({3'd0, b_i[30:23]});
    end
    s1_sign_d     = a_i[31] ^ b_i[31];
    s1_spc_d.nan  = a_nan | b_nan | (a_inf & b_zero) | (a_zero & b_inf);
    s1_spc_d.inf  = a_inf | b_inf;
    s1_spc_d.zero = a_zero | b_zero;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_sign_q <= s1_sign_d;
      s1_ea_q   <= s1_ea_d;
      s1_eb_q   <= s1_eb_d;
      s1_ma_q   <= s1_ma_d;
      s1_mb_q   <= s1_mb_d;
      s1_spc_q  <= s1_spc_d;
    end
  end

  // Stage 2: multiply significands, add exponents
  logic               s2_sign_q;
  logic signed [10:0] s2_exp_q;
  logic [47:0]        s2_prod_q;
  plc_pkg::spc_t      s2_spc_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s2_sign_q <= s1_sign_q;
      s2_exp_q  <= s1_ea_q + s1_eb_q - 11'sd127;
      s2_prod_q <= s1_ma_q * s1_mb_q;
      s2_spc_q  <= s1_spc_q;
    end
  end

  // Stage 3: normalize, shift into subnormal range, form round bit
  logic [47:0]        nm, ms;
  logic signed [10:0] e_n, sh_w;
  logic [5:0]         sh;
  logic [7:0]         ef;
  logic               lost;
  logic               s3_rnd_d, s3_ovf_d;

  logic               s3_sign_q, s3_rnd_q, s3_ovf_q;
  logic [30:0]        s3_pk_q;
  plc_pkg::spc_t      s3_spc_q;

  always_comb begin
    if (s2_prod_q[47]) begin
      nm  = s2_prod_q;
      e_n = s2_exp_q + 11'sd1;
    end else begin
      nm  = {s2_prod_q[46:0], 1'b0};
      e_n = s2_exp_q;
    end
    sh_w = 11'sd1 - e_n;
    if (e_n < 11'sd1) begin
      sh = (sh_w > 11'sd63) ? 6'd63 : sh_w[5:0];
      ef = 8'd0;
    end else begin
      sh = 6'd0;
      ef = e_n[7:0];
    end
    ms       = nm >> sh;
    lost     = |(nm & ~({48{1'b1}} << sh));
    s3_rnd_d = ms[23] & ((|ms[22:0]) | lost | ms[24]);
    s3_ovf_d = e_n > 11'sd254;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s3_sign_q <= s2_sign_q;
      s3_pk_q   <= {ef, ms[46:24]};
      s3_rnd_q  <= s3_rnd_d;
      s3_ovf_q  <= s3_ovf_d;
      s3_spc_q  <= s2_spc_q;
    end
  end

  // Stage 4: round and select specials
  logic [31:0] p_d, p_q;

  always_comb begin
    if (s3_spc_q.nan) begin
      p_d = plc_pkg::F_QNAN;
    end else if (s3_spc_q.inf || s3_ovf_q) begin
      p_d = {s3_sign_q, 8'hFF, 23'd0};
    end else if (s3_spc_q.zero) begin
      p_d = {s3_sign_q, 31'd0};
    end else begin
      p_d = {s3_sign_q, s3_pk_q + {30'd0, s3_rnd_q}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

[rtl/core/plc_fadd.sv]
// Four-stage single-precision adder, round to nearest even, subnormals kept.
`default_nettype none

module plc_fadd (
  input  logic                            clk_i,
  input  logic [plc_pkg::FP_STAGES-1:0]   en_i,
  input  logic [31:0]                     a_i,
  input  logic [31:0]                     b_i,
  output logic [31:0]                     s_o
);

  // Stage 1: unpack, order by magnitude, exponent difference
  logic [31:0]   big, sml;
  logic          a_inf, b_inf, a_nan, b_nan;
  plc_pkg::spc_t s1_spc_d;

  logic          s1_sl_q, s1_ss_q, s1_isgn_q;
  logic [7:0]    s1_el_q, s1_d_q;
  logic [23:0]   s1_ml_q, s1_ms_q;
  plc_pkg::spc_t s1_spc_q;

  logic [7:0]    el_d, es_d;

  always_comb begin
    a_inf = (a_i[30:23] == 8'hFF) && (a_i[22:0] == 23'd0);
    b_inf = (b_i[30:23] == 8'hFF) && (b_i[22:0] == 23'd0);
    a_nan = (a_i[30:23] == 8'hFF) && (a_i[22:0] != 23'd0);
    b_nan = (b_i[30:23] == 8'hFF) && (b_i[22:0] != 23'd0);
    if (a_i[30:0] >= b_i[30:0]) begin
      big = a_i;
      sml = b_i;
    end else begin
      big = b_i;
      sml = a_i;
    end
    el_d = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es_d = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    s1_spc_d.nan  = a_nan | b_nan | (a_inf & b_inf & (a_i[31] ^ b_i[31]));
    s1_spc_d.inf  = a_inf | b_inf;
    s1_spc_d.zero = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_sl_q   <= big[31];
      s1_ss_q   <= sml[31];
      s1_isgn_q <= a_inf ? a_i[31] : b_i[31];
      s1_el_q   <= el_d;
      s1_d_q    <= el_d - es_d;
      s1_ml_q   <= {big[30:23] != 8'd0, big[22:0]};
      s1_ms_q   <= {sml[30:23] != 8'd0, sml[22:0]};
      s1_spc_q  <= s1_spc_d;
    end
  end

  // Stage 2: align smaller operand with sticky, add or subtract
  logic [4:0]  dc;
  logic [26:0] ext, al;
  logic [27:0] sum_d;

  logic          s2_sl_q, s2_zs_q, s2_isgn_q;
  logic [7:0]    s2_el_q;
  logic [27:0]   s2_sum_q;
  plc_pkg::spc_t s2_spc_q;

  always_comb begin
    dc  = (s1_d_q > 8'd31) ? 5'd31 : s1_d_q[4:0];
    ext = {s1_ms_q, 3'd0};
    al  = ext >> dc;
    al[0] = al[0] | (|(ext & ~({27{1'b1}} << dc)));
    if (s1_sl_q ^ s1_ss_q) begin
      sum_d = {1'b0, s1_ml_q, 3'd0} - {1'b0, al};
    end else begin
      sum_d = {1'b0, s1_ml_q, 3'd0} + {1'b0, al};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s2_sl_q   <= s1_sl_q;
      s2_zs_q   <= s1_sl_q & s1_ss_q;
      s2_isgn_q <= s1_isgn_q;
      s2_el_q   <= s1_el_q;
      s2_sum_q  <= sum_d;
      s2_spc_q  <= s1_spc_q;
    end
  end

  // Stage 3: normalize, limited by the subnormal boundary
  logic [4:0]  lz, sft;
  logic [7:0]  elm1;
  logic [26:0] r_d, shl;
  logic [8:0]  e_d;

  logic          s3_sign_q, s3_isgn_q;
  logic [26:0]   s3_r_q;
  logic [8:0]    s3_e_q;
  plc_pkg::spc_t s3_spc_q;

  always_comb begin
    lz   = plc_pkg::lzc27(s2_sum_q[26:0]);
    elm1 = s2_el_q - 8'd1;
    sft  = ({3'd0, lz} > elm1) ? elm1[4:0] : lz;
    shl  = s2_sum_q[26:0] << sft;
    if (s2_sum_q[27]) begin
      r_d = {s2_sum_q[27:2], s2_sum_q[1] | s2_sum_q[0]};
      e_d = {1'b0, s2_el_q} + 9'd1;
    end else begin
      r_d = shl;
      e_d = shl[26] ? ({1'b0, s2_el_q} - {4'd0, sft}) : 9'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s3_sign_q     <= (s2_sum_q == 28'd0) ? s2_zs_q : s2_sl_q;
      s3_isgn_q     <= s2_isgn_q;
      s3_r_q        <= r_d;
      s3_e_q        <= e_d;
      s3_spc_q.nan  <= s2_spc_q.nan;
      s3_spc_q.inf  <= s2_spc_q.inf;
      s3_spc_q.zero <= s2_sum_q == 28'd0;
    end
  end

  // Stage 4: round and select specials
  logic        rnd;
  logic [31:0] s_d, s_q;

  always_comb begin
    rnd = s3_r_q[2] & (s3_r_q[1] | s3_r_q[0] | s3_r_q[3]);
    if (s3_spc_q.nan) begin
      s_d = plc_pkg::F_QNAN;
    end else if (s3_spc_q.inf) begin
      s_d = {s3_isgn_q, 8'hFF, 23'd0};
    end else if (s3_spc_q.zero) begin
      s_d = {s3_sign_q, 31'd0};
    end else if (s3_e_q > 9'd254) begin
      s_d = {s3_sign_q, 8'hFF, 23'd0};
    end else begin
      s_d = {s3_sign_q, {s3_e_q[7:0], s3_r_q[25:3]} + {30'd0, rnd}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      s_q <= s_d;
    end
  end

  assign s_o = s_q;

endmodule

`default_nettype wire

[rtl/core/pixel_luminance_converter.sv]
// Top level: Rec.709 relative luminance of one pixel per cycle while the receiver is ready, as an IEEE single.
//
// Channels: pixel words enter on in_valid_i/in_ready_o with in_data_i, results
// leave on out_valid_o/out_ready_i with out_data_o (luma_bits, zeroed). The
// format register is written over cfg_valid_i/cfg_ready_o; cfg_ready_o is
// always high. Write it only while no pixel is in flight.
// Throughput: one pixel per cycle, sustained while out_ready_i stays high.
// Pipeline: 18 register stages from accepted pixel to valid result: one decode
// stage, two chained four-stage multipliers per color lane (scale, then
// weight), two chained four-stage adders (red plus green, then plus blue) and
// one output stage that clamps non-finite or negative nonzero luminance to
// zero, or gives 1.0 for the unsupported format.
// Every stage carries a valid bit; a stage loads when it is empty or the stage
// after it moves, so bubbles collapse and the input side keeps accepting while
// a finished result waits. A receiver stall backs up stage by stage; no word
// is lost or repeated.
// Reset clears all valid bits and sets the format to 32-bit float RGB.
`default_nettype none

module pixel_luminance_converter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [2:0]      cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  plc_pkg::pix_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output plc_pkg::luma_t  out_data_o
);

  localparam int unsigned NS  = 18;
  localparam int unsigned M1  = 1;
  localparam int unsigned M2  = M1 + plc_pkg::FP_STAGES;
  localparam int unsigned A1  = M2 + plc_pkg::FP_STAGES;
  localparam int unsigned A2  = A1 + plc_pkg::FP_STAGES;
  localparam int unsigned FIN = A2 + plc_pkg::FP_STAGES;

  // Format register
  logic [2:0] fmt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= plc_pkg::FMT_F32;
    end else if (cfg_valid_i) begin
      fmt_q <= cfg_data_i;
    end
  end

  // Stage valid bits and load enables
  logic [NS-1:0] vld_q;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NS-1];

  // Decode
  logic [2:0][31:0] x;
  logic [31:0]      scale;

  plc_decode u_decode (
    .clk_i   (clk_i),
    .en_i    (en[0]),
    .fmt_i   (fmt_q),
    .pix_i   (in_data_i),
    .x_o     (x),
    .scale_o (scale)
  );

  // Per-lane weights; single-channel formats pass red unweighted
  logic [2:0][31:0] wgt;

  always_comb begin
    wgt[0] = ((fmt_q == plc_pkg::FMT_R16) || (fmt_q == plc_pkg::FMT_R8)) ?
             plc_pkg::F_ONE : plc_pkg::F_W_RED;
    wgt[1] = plc_pkg::F_W_GRN;
    wgt[2] = plc_pkg::F_W_BLU;
  end

  // Scale, then weight, per color lane
  logic [2:0][31:0] lin, term;

  for (genvar l = 0; l < plc_pkg::NUM_LANES; l++) begin : g_lane
    plc_fmul u_scale (
      .clk_i (clk_i),
      .en_i  (en[M2-1:M1]),
      .a_i   (x[l]),
      .b_i   (scale),
      .p_o   (lin[l])
    );

    plc_fmul u_weight (
      .clk_i (clk_i),
      .en_i  (en[A1-1:M2]),
      .a_i   (lin[l]),
      .b_i   (wgt[l]),
      .p_o   (term[l])
    );
  end

  // Red plus green
  logic [31:0] rg;

  plc_fadd u_add_rg (
    .clk_i (clk_i),
    .en_i  (en[A2-1:A1]),
    .a_i   (term[0]),
    .b_i   (term[1]),
    .s_o   (rg)
  );

  // Delay blue term alongside the first adder
  logic [plc_pkg::FP_STAGES-1:0][31:0] blu_q;

  always_ff @(posedge clk_i) begin
    if (en[A1]) blu_q[0] <= term[2];
    for (int k = 1; k < plc_pkg::FP_STAGES; k++) begin
      if (en[A1+k]) blu_q[k] <= blu_q[k-1];
    end
  end

  // Plus blue
  logic [31:0] lum;

  plc_fadd u_add_b (
    .clk_i (clk_i),
    .en_i  (en[FIN-1:A2]),
    .a_i   (rg),
    .b_i   (blu_q[plc_pkg::FP_STAGES-1]),
    .s_o   (lum)
  );

  // Output stage: clamp and unsupported-format override
  plc_pkg::luma_t res_d, res_q;

  always_comb begin
    if (fmt_q == plc_pkg::FMT_NONE) begin
      res_d.luma_bits = plc_pkg::F_ONE;
      res_d.zeroed    = 1'b0;
    end else if ((lum[30:23] == 8'hFF) || (lum[31] && (lum[30:0] != 31'd0))) begin
      res_d.luma_bits = 32'd0;
      res_d.zeroed    = 1'b1;
    end else begin
      res_d.luma_bits = lum;
      res_d.zeroed    = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[FIN]) res_q <= res_d;
  end

  assign out_data_o = res_q;

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for the pixel luminance converter, with directed and random pixels.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned LATENCY   = 17;
  localparam int unsigned STALL_MAX = 2000;
  localparam int unsigned LONG_HOLD = 300;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           cfg_valid_i = 1'b0;
  logic           cfg_ready_o;
  logic [2:0]     cfg_data_i = '0;
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  plc_pkg::pix_t  in_data_i = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  plc_pkg::luma_t out_data_o;

  pixel_luminance_converter DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  plc_pkg::luma_t pending_luma[$];
  logic [2:0]     cur_format = plc_pkg::FMT_F32;
  int unsigned    err_count = 0;
  int unsigned    words_in = 0;
  int unsigned    words_out = 0;
  int unsigned    zeroed_seen = 0;
  int unsigned    send_gap_pct = 0;
  int unsigned    recv_gap_pct = 0;
  bit             hold_req = 1'b0;
  int unsigned    hold_left = 0;
  int unsigned    idle_cycles = 0;

  // ---------------------------------------------------------------------------
  // Single-precision arithmetic: computed in double (products exactly), then one rounding to single
  // ---------------------------------------------------------------------------
  function automatic real sgl_to_real(logic [31:0] f);
    logic [7:0] e;
    real        r;
    e = f[30:23];
    if (e == 8'hFF) return $bitstoreal({f[31], 11'h7FF, f[22:0], 29'd0});
    if (e == 8'd0) begin
      if (f[22:0] == 23'd0) return $bitstoreal({f[31], 63'd0});
      r = $itor(f[22:0]) * (2.0 ** -149);
      return f[31] ? -r : r;
    end
    return $bitstoreal({f[31], 11'(int'(e) - 127 + 1023), f[22:0], 29'd0});
  endfunction

  function automatic logic [31:0] round_to_sgl(real r);
    logic [63:0] d;
    logic [63:0] m64;
    logic [63:0] q;
    logic        s;
    logic        rb;
    logic        st;
    int          eb;
    int          sh;
    d = $realtobits(r);
    s = d[63];
    if (d[62:52] == 11'h7FF) return {s, 8'hFF, (d[51:0] != 0) ? 23'h40_0000 : 23'd0};
    if (d[62:52] == 11'd0) return {s, 31'd0};
    eb  = int'(d[62:52]) - 1023 + 127;
    m64 = {11'd0, 1'b1, d[51:0]};
    sh  = (eb >= 1) ? 29 : 30 - eb;
    if (sh > 60) return {s, 31'd0};
    q  = m64 >> sh;
    rb = m64[sh-1];
    st = (m64 & ((64'd1 << (sh - 1)) - 64'd1)) != 64'd0;
    if (rb && (st || q[0])) q = q + 64'd1;
    if (eb >= 1) begin
      if (q[24]) begin
        q  = q >> 1;
        eb = eb + 1;
      end
      if (eb >= 255) return {s, 8'hFF, 23'd0};
      return {s, 8'(eb), q[22:0]};
    end
    // subnormal; a carry into bit 23 lands on the smallest normal
    return {s, q[30:0]};
  endfunction

  function automatic logic [31:0] sgl_mul(logic [31:0] a, logic [31:0] b);
    return round_to_sgl(sgl_to_real(a) * sgl_to_real(b));
  endfunction

  function automatic logic [31:0] sgl_add(logic [31:0] a, logic [31:0] b);
    return round_to_sgl(sgl_to_real(a) + sgl_to_real(b));
  endfunction

  function automatic logic [31:0] half_bits_to_sgl(logic [15:0] h);
    logic [9:0] man;
    int         e;
    man = h[9:0];
    if (h[14:10] == 5'h1F) return {h[15], 8'hFF, man, 13'd0};
    if (h[14:10] != 5'd0) return {h[15], 8'(int'(h[14:10]) + 112), man, 13'd0};
    if (man == 10'd0) return {h[15], 31'd0};
    // normalize the subnormal half
    e = 113;
    while (!man[9]) begin
      man = man << 1;
      e   = e - 1;
    end
    man = man << 1;
    return {h[15], 8'(e - 1), man, 13'd0};
  endfunction

  function automatic logic [31:0] unorm8_val(logic [31:0] w);
    return sgl_mul(round_to_sgl($itor(w[7:0])), plc_pkg::F_INV255);
  endfunction

  function automatic logic [31:0] unorm16_val(logic [31:0] w);
    return sgl_mul(round_to_sgl($itor(w[15:0])), plc_pkg::F_INV65K);
  endfunction

  function automatic logic [31:0] rec709_sum(logic [31:0] r, logic [31:0] g,
                                             logic [31:0] b);
    return sgl_add(sgl_add(sgl_mul(plc_pkg::F_W_RED, r), sgl_mul(plc_pkg::F_W_GRN, g)),
                   sgl_mul(plc_pkg::F_W_BLU, b));
  endfunction

  // Expected luminance word for one pixel under a given format
  function automatic plc_pkg::luma_t predict_luma(logic [2:0] fmt, plc_pkg::pix_t p);
    logic [31:0]    l;
    plc_pkg::luma_t res;
    case (fmt)
      plc_pkg::FMT_F32:     l = rec709_sum(p.chan0, p.chan1, p.chan2);
      plc_pkg::FMT_F16:     l = rec709_sum(half_bits_to_sgl(p.chan0[15:0]),
                                           half_bits_to_sgl(p.chan1[15:0]),
                                           half_bits_to_sgl(p.chan2[15:0]));
      plc_pkg::FMT_U16_RGB: l = rec709_sum(unorm16_val(p.chan0), unorm16_val(p.chan1),
                                           unorm16_val(p.chan2));
      plc_pkg::FMT_U8_BGR:  l = rec709_sum(unorm8_val(p.chan2), unorm8_val(p.chan1),
                                           unorm8_val(p.chan0));
      plc_pkg::FMT_U8_RG:   l = sgl_add(sgl_mul(plc_pkg::F_W_RED, unorm8_val(p.chan0)),
                                        sgl_mul(plc_pkg::F_W_GRN, unorm8_val(p.chan1)));
      plc_pkg::FMT_R16:     l = unorm16_val(p.chan0);
      plc_pkg::FMT_R8:      l = unorm8_val(p.chan0);
      default:              l = plc_pkg::F_ONE;
    endcase
    res.luma_bits = l;
    res.zeroed    = 1'b0;
    // clamp NaN, infinity and negative nonzero values
    if (l[30:23] == 8'hFF || (l[31] && l[30:0] != 31'd0)) begin
      res.luma_bits = 32'd0;
      res.zeroed    = 1'b1;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting and result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch %s: got %h, expected %h", $time, what, got, want);
    err_count++;
  endtask

  // Check each accepted word, then pick the next ready level
  always @(posedge clk_i) begin
    plc_pkg::luma_t want;
    if (out_valid_o && out_ready_i) begin
      words_out++;
      if (out_data_o.zeroed) zeroed_seen++;
      if (pending_luma.size() == 0) begin
        report_mismatch("unexpected word", out_data_o.luma_bits, 32'd0);
      end else begin
        want = pending_luma.pop_front();
        if (out_data_o.luma_bits !== want.luma_bits)
          report_mismatch("luma_bits", out_data_o.luma_bits, want.luma_bits);
        if (out_data_o.zeroed !== want.zeroed)
          report_mismatch("zeroed", 32'(out_data_o.zeroed), 32'(want.zeroed));
      end
    end
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_MAX) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Drop the input, drain the pipeline, then write the format register
  task automatic set_format(logic [2:0] fmt);
    in_valid_i <= 1'b0;
    while (pending_luma.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= fmt;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_format = fmt;
  endtask

  // Offer one pixel, idling first at random; hold it until accepted
  task automatic send_pixel(plc_pkg::pix_t p);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (!in_ready_o);
    pending_luma.push_back(predict_luma(cur_format, p));
    words_in++;
  endtask

  // Random channel word shaped for the format, with some raw noise
  function automatic logic [31:0] rand_chan(logic [2:0] fmt);
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(9) < 2) return w;
    case (fmt)
      plc_pkg::FMT_F32: begin
        w[30:23] = 8'($urandom_range(150, 100));
        if ($urandom_range(9) != 0) w[31] = 1'b0;
        if ($urandom_range(29) == 0) w[30:23] = 8'($urandom_range(1) ? 8'hFF : 8'h00);
        if ($urandom_range(29) == 0) w[30:23] = 8'($urandom_range(254, 250));
      end
      plc_pkg::FMT_F16: begin
        if ($urandom_range(9) != 0) w[15] = 1'b0;
        if ($urandom_range(19) == 0) w[14:10] = 5'($urandom_range(1) ? 5'h1F : 5'h00);
      end
      default: begin
        if ($urandom_range(19) == 0) w[15:0] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      end
    endcase
    return w;
  endfunction

  typedef struct {
    logic [2:0]     fmt;
    plc_pkg::pix_t  pix;
    bit             known;
    plc_pkg::luma_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic add_row(logic [2:0] fmt, logic [31:0] c0, logic [31:0] c1,
                         logic [31:0] c2, bit known, logic [31:0] lb, logic z);
    dir_row_t row;
    row.fmt   = fmt;
    row.pix   = '{chan0: c0, chan1: c1, chan2: c2};
    row.known = known;
    row.want  = '{luma_bits: lb, zeroed: z};
    dir_rows.push_back(row);
  endtask

  initial begin
    plc_pkg::pix_t  p;
    plc_pkg::luma_t got_exp;
    logic [2:0]     fmt;
    int unsigned    phase_gap[3][2];

    // Directed pixels: extremes, every format, clamping and negative zero
    add_row(plc_pkg::FMT_F32, 32'h0, 32'h0, 32'h0, 1, 32'h0000_0000, 1'b0);
    add_row(plc_pkg::FMT_F32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
            32'h0, 1'b1);
    add_row(plc_pkg::FMT_F32, 32'h7F80_0000, 32'h0, 32'h0, 1, 32'h0, 1'b1);
    add_row(plc_pkg::FMT_F32, 32'hBF80_0000, 32'h0, 32'h0, 1, 32'h0, 1'b1);
    add_row(plc_pkg::FMT_F32, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1,
            32'h8000_0000, 1'b0);
    add_row(plc_pkg::FMT_F32, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 0,
            32'h0, 1'b0);
    add_row(plc_pkg::FMT_F32, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 0,
            32'h0, 1'b0);
    add_row(plc_pkg::FMT_F32, 32'h0000_0001, 32'h007F_FFFF, 32'h0080_0000, 0,
            32'h0, 1'b0);
    add_row(plc_pkg::FMT_F16, 32'h3C00, 32'h3C00, 32'h3C00, 0, 32'h0, 1'b0);
    add_row(plc_pkg::FMT_F16, 32'h7C00, 32'h0, 32'h0, 1, 32'h0, 1'b1);
    add_row(plc_pkg::FMT_F16, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 1,
            32'h0, 1'b0);
    add_row(plc_pkg::FMT_F16, 32'h8000, 32'h8000, 32'h8000, 1, 32'h8000_0000, 1'b0);
    add_row(plc_pkg::FMT_F16, 32'h0001, 32'h03FF, 32'h7BFF, 0, 32'h0, 1'b0);
    add_row(plc_pkg::FMT_U16_RGB, 32'hFFFF_0000, 32'h0, 32'h0, 1, 32'h0, 1'b0);
    add_row(plc_pkg::FMT_U16_RGB, 32'hFFFF, 32'hFFFF, 32'hFFFF, 0, 32'h0, 1'b0);
    add_row(plc_pkg::FMT_U8_BGR, 32'hFF, 32'h0, 32'h0, 0, 32'h0, 1'b0);
    add_row(plc_pkg::FMT_U8_BGR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0,
            32'h0, 1'b0);
    add_row(plc_pkg::FMT_U8_RG, 32'hFF, 32'hFF, 32'hFFFF_FFFF, 0, 32'h0, 1'b0);
    add_row(plc_pkg::FMT_U8_RG, 32'hFFFF_FF00, 32'hFFFF_FF00, 32'hFF, 1, 32'h0, 1'b0);
    add_row(plc_pkg::FMT_R16, 32'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'h0, 1'b0);
    add_row(plc_pkg::FMT_R16, 32'hFFFF_0000, 32'h1234, 32'h5678, 1, 32'h0, 1'b0);
    add_row(plc_pkg::FMT_R8, 32'hFF, 32'h0, 32'h0, 0, 32'h0, 1'b0);
    add_row(plc_pkg::FMT_R8, 32'hFFFF_FF00, 32'hFF, 32'hFF, 1, 32'h0, 1'b0);
    add_row(plc_pkg::FMT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
            plc_pkg::F_ONE, 1'b0);
    add_row(plc_pkg::FMT_NONE, 32'h0, 32'h0, 32'h0, 1, plc_pkg::F_ONE, 1'b0);

    // sender / receiver idle percentages per random phase
    phase_gap = '{'{27, 60}, '{60, 27}, '{0, 0}};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table; format changes only while the pipeline is empty
    foreach (dir_rows[i]) begin
      if (dir_rows[i].fmt != cur_format || i == 0) set_format(dir_rows[i].fmt);
      if (dir_rows[i].known) begin
        got_exp = predict_luma(cur_format, dir_rows[i].pix);
        if (got_exp != dir_rows[i].want)
          report_mismatch("predictor on directed row", got_exp.luma_bits,
                          dir_rows[i].want.luma_bits);
      end
      send_pixel(dir_rows[i].pix);
    end

    // Random phases: blocks of pixels under random formats
    for (int ph = 0; ph < 3; ph++) begin
      send_gap_pct = phase_gap[ph][0];
      recv_gap_pct = phase_gap[ph][1];
      for (int blk = 0; blk < 8; blk++) begin
        if (blk == 0) fmt = plc_pkg::FMT_F32;
        else if (blk == 7) fmt = plc_pkg::FMT_NONE;
        else fmt = 3'($urandom_range(7));
        set_format(fmt);
        if (ph == 2 && blk == 1) hold_req = 1'b1;
        for (int k = 0; k < 62; k++) begin
          p.chan0 = rand_chan(cur_format);
          p.chan1 = rand_chan(cur_format);
          p.chan2 = rand_chan(cur_format);
          send_pixel(p);
        end
      end
    end
    in_valid_i <= 1'b0;

    // Drain and let the pipeline settle
    while (pending_luma.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("Sent %0d pixels over all eight formats, got %0d luminance words (%0d zeroed).",
             words_in, words_out, zeroed_seen);
    $display("Covered both idle mixes, full rate and a %0d-cycle receiver hold; %0d errors.",
             LONG_HOLD, err_count);
    if (err_count == 0 && pending_luma.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[pixel_luminance_converter.f]
rtl/core/plc_pkg.sv
rtl/core/plc_decode.sv
rtl/core/plc_fmul.sv
rtl/core/plc_fadd.sv
rtl/core/pixel_luminance_converter.sv
dv/tb_top.sv
